### rtl/core/sm_pkg.sv
// ----------------------------------------------------------------------------
// sm_pkg : shared types and constants for the stack machine
// Command and status codes, default sizes, FSM state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sm_pkg;

    localparam int unsigned SM_STACK_DEPTH = 256;
    localparam int unsigned SM_MEM_DEPTH   = 1024;

    localparam int unsigned CMD_W    = 4;
    localparam int unsigned VAL_W    = 64;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ALLOC_W  = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_LIT   = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DUP   = 4'd4,
        CMD_DROP  = 4'd5,
        CMD_SWAP  = 4'd6,
        CMD_OVER  = 4'd7,
        CMD_ROT   = 4'd8,
        CMD_FETCH = 4'd9,
        CMD_STORE = 4'd10,
        CMD_ALLOC = 4'd11,
        CMD_SHOW  = 4'd12
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_BAD_ADDR  = 3'd3,
        ST_MEM_FULL  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_MUL  = 2'd1,
        FSM_EXEC = 2'd2
    } fsm_t;

endpackage

`default_nettype wire

### rtl/core/rpn_stack_machine.sv
// ----------------------------------------------------------------------------
// rpn_stack_machine : stack machine with data stack and word memory
// Top two stack entries live in registers, the rest in a stack memory.
// ----------------------------------------------------------------------------
// Flow: an accepted word goes IDLE -> EXEC, which registers its result word;
//   mul goes IDLE -> MUL -> EXEC (three 32x32 partial products on one shared multiplier).
// Accept: a new word is taken only in IDLE, after the last one has executed; EXEC
//   uses the registered stack/data memory reads and holds while the output stalls.
// Reset: synchronous active-low; clears depth, alloc count, mul step, FSM and output
//   valid. Stack and data memories are not cleared (unwritten entries never shown).
`default_nettype none

module rpn_stack_machine #(
    parameter int unsigned STACK_DEPTH = sm_pkg::SM_STACK_DEPTH,
    parameter int unsigned MEM_DEPTH   = sm_pkg::SM_MEM_DEPTH,
    localparam int unsigned DW    = $clog2(STACK_DEPTH + 1),
    localparam int unsigned OUT_W = 3 + 64 + DW + 10,
    localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [71:0]       s_tdata,   // command[3:0], literal[67:4]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_TW-1:0]      m_tdata    // status, top_value, depth, alloc_address
);
    import sm_pkg::*;

    localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned CW = $clog2(MEM_DEPTH + 1);

    // memories
    logic [VAL_W-1:0]  stk_mem [STACK_DEPTH];
    logic [WORD_W-1:0] dat_mem [MEM_DEPTH];

    // control / cached state
    fsm_t             state_reg, state_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [VAL_W-1:0] tos_reg, tos_next;
    logic [VAL_W-1:0] nos_reg, nos_next;
    cmd_t             cmd_reg;
    logic [VAL_W-1:0] lit_reg;
    logic [VAL_W-1:0] rd0_reg;   // entry depth-3
    logic [VAL_W-1:0] rd1_reg;   // entry depth-4
    logic [WORD_W-1:0] drd_reg;  // data word at tos address
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [1:0]       mcnt_reg, mcnt_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic s_fire, do_exec;
    logic [SW-1:0] ra0, ra1;

    // stack write
    logic              swr_en;
    logic [SW-1:0]     swr_addr;
    logic [VAL_W-1:0]  swr_data;
    // data memory write
    logic              dwr_en;
    logic [AW-1:0]     dwr_addr;
    logic [WORD_W-1:0] dwr_data;

    // shared 32x32 multiplier
    logic [WORD_W-1:0] mul_a, mul_b;
    logic [VAL_W-1:0]  mul_p;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == FSM_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_reg);
    assign do_exec  = (state_reg == FSM_EXEC) && (!out_valid_reg || m_tready);

    assign ra0 = SW'(depth_reg - DW'(3));
    assign ra1 = SW'(depth_reg - DW'(4));

    // memories: registered reads issued with the accepted word
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd0_reg <= stk_mem[ra0];
            rd1_reg <= stk_mem[ra1];
            drd_reg <= dat_mem[tos_reg[AW-1:0]];
        end
        if (swr_en) begin
            stk_mem[swr_addr] <= swr_data;
        end
        if (dwr_en) begin
            dat_mem[dwr_addr] <= dwr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg <= cmd_t'(s_tdata[3:0]);
            lit_reg <= s_tdata[67:4];
        end
        acc_reg  <= acc_next;
        tos_reg  <= tos_next;
        nos_reg  <= nos_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_IDLE;
            depth_reg     <= '0;
            cnt_reg       <= '0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            cnt_reg       <= cnt_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // multiplier operand select: lo*lo, lo*hi, hi*lo (nos * tos)
    always_comb begin
        unique case (mcnt_reg)
            2'd0:    begin mul_a = nos_reg[31:0];  mul_b = tos_reg[31:0];  end
            2'd1:    begin mul_a = nos_reg[31:0];  mul_b = tos_reg[63:32]; end
            default: begin mul_a = nos_reg[63:32]; mul_b = tos_reg[31:0];  end
        endcase
    end
    assign mul_p = VAL_W'(mul_a) * VAL_W'(mul_b);

    // next state and execute
    always_comb begin
        logic [VAL_W-1:0]  t, n, m, m2, res;
        logic [DW-1:0]     d;
        logic              ge1, ge2, ge3, full, addr_ok;
        logic [31:0]       cnt32;
        logic [ALLOC_W-1:0] given;
        status_t           st;

        state_next     = state_reg;
        depth_next     = depth_reg;
        cnt_next       = cnt_reg;
        tos_next       = tos_reg;
        nos_next       = nos_reg;
        acc_next       = acc_reg;
        mcnt_next      = mcnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        swr_en   = 1'b0;
        swr_addr = SW'(depth_reg - DW'(2));
        swr_data = nos_reg;
        dwr_en   = 1'b0;
        dwr_addr = tos_reg[AW-1:0];
        dwr_data = nos_reg[31:0];

        t  = tos_reg;
        n  = nos_reg;
        m  = rd0_reg;
        m2 = rd1_reg;
        d  = depth_reg;
        ge1  = (d >= DW'(1));
        ge2  = (d >= DW'(2));
        ge3  = (d >= DW'(3));
        full = (d == DW'(STACK_DEPTH));
        addr_ok = !t[63] && (t < VAL_W'(cnt_reg));
        st    = ST_OK;
        given = '0;
        res   = '0;
        cnt32 = '0;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    if (cmd_t'(s_tdata[3:0]) == CMD_MUL && ge2) begin
                        state_next = FSM_MUL;
                        mcnt_next  = 2'd0;
                        acc_next   = '0;
                    end else begin
                        state_next = FSM_EXEC;
                    end
                end
            end
            FSM_MUL: begin
                if (mcnt_reg == 2'd0) begin
                    acc_next = mul_p;
                end else begin
                    acc_next = acc_reg + {mul_p[31:0], 32'd0};
                end
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd2) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (do_exec) begin
                    state_next = FSM_IDLE;
                    unique case (cmd_reg)
                        CMD_LIT: begin
                            if (full) begin
                                st = ST_OVERFLOW;
                            end else begin
                                tos_next = lit_reg; nos_next = t;
                                swr_en = ge2; depth_next = d + DW'(1);
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL: begin
                            if (!ge2) begin
                                st = ST_UNDERFLOW;
                            end else begin
                                if (cmd_reg == CMD_ADD)      res = n + t;
                                else if (cmd_reg == CMD_SUB) res = n - t;
                                else                         res = acc_reg;
                                tos_next = res; nos_next = m;
                                depth_next = d - DW'(1);
                            end
                        end
                        CMD_DUP: begin
                            if (!ge1) begin
                                st = ST_UNDERFLOW;
                            end else if (full) begin
                                st = ST_OVERFLOW;
                            end else begin
                                nos_next = t; swr_en = ge2;
                                depth_next = d + DW'(1);
                            end
                        end
                        CMD_DROP: begin
                            if (!ge1) begin
                                st = ST_UNDERFLOW;
                            end else begin
                                tos_next = n; nos_next = m;
                                depth_next = d - DW'(1);
                            end
                        end
                        CMD_SWAP: begin
                            if (!ge2) begin
                                st = ST_UNDERFLOW;
                            end else begin
                                tos_next = n; nos_next = t;
                            end
                        end
                        CMD_OVER: begin
                            if (!ge2) begin
                                st = ST_UNDERFLOW;
                            end else if (full) begin
                                st = ST_OVERFLOW;
                            end else begin
                                tos_next = n; nos_next = t; swr_en = 1'b1;
                                depth_next = d + DW'(1);
                            end
                        end
                        CMD_ROT: begin
                            // a b c -> b c a (third entry comes to top)
                            if (!ge3) begin
                                st = ST_UNDERFLOW;
                            end else begin
                                tos_next = m; nos_next = t;
                                swr_en = 1'b1; swr_addr = SW'(d - DW'(3));
                            end
                        end
                        CMD_FETCH: begin
                            if (!ge1) begin
                                st = ST_UNDERFLOW;
                            end else if (!addr_ok) begin
                                st = ST_BAD_ADDR;
                                tos_next = n; nos_next = m;
                                depth_next = d - DW'(1);
                            end else begin
                                tos_next = {{32{drd_reg[31]}}, drd_reg};
                            end
                        end
                        CMD_STORE: begin
                            if (!ge2) begin
                                st = ST_UNDERFLOW;
                            end else begin
                                tos_next = m; nos_next = m2;
                                depth_next = d - DW'(2);
                                if (addr_ok) dwr_en = 1'b1;
                                else         st = ST_BAD_ADDR;
                            end
                        end
                        CMD_ALLOC: begin
                            if (cnt_reg == CW'(MEM_DEPTH)) begin
                                st = ST_MEM_FULL;
                            end else begin
                                dwr_en = 1'b1; dwr_addr = AW'(cnt_reg);
                                dwr_data = '0;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        default: begin
                            // show and unused codes: no change
                        end
                    endcase

                    cnt32 = 32'(cnt_next);
                    if (cmd_reg == CMD_ALLOC && st == ST_OK) begin
                        given = ALLOC_W'(cnt_reg);
                    end else if (cnt32 > 32'd1023) begin
                        given = ALLOC_W'(1023);
                    end else begin
                        given = cnt32[ALLOC_W-1:0];
                    end

                    out_next = {given, depth_next,
                                (depth_next == '0) ? {VAL_W{1'b0}} : tos_next, st};
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MEM_DEPTH))
        else $error("alloc count beyond memory size");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while one in flight");

    a_depth_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_exec |=> depth_reg == $past(depth_reg))
        else $error("depth changed outside execute");

endmodule

`default_nettype wire
